[design/smd_pkg.sv]
// smd_pkg: shared types and constants of the slew-limited mecanum drive.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package smd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LINEAR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TURN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX    = 3'd4;

    localparam logic [14:0] RST_STEP_LINEAR = 15'd20;
    localparam logic [14:0] RST_STEP_TURN   = 15'd82;
    localparam logic [15:0] RST_ARM_LENGTH  = 16'd1331;
    localparam logic [15:0] RST_DUTY_GAIN   = 16'd15481;
    localparam logic [14:0] RST_DUTY_MAX    = 15'd15565;

    localparam int NUM_WHEELS = 4;
    localparam int ROUND_SHIFT = 24;

    typedef struct packed {
        logic signed [15:0] target_vx;
        logic signed [15:0] target_vy;
        logic signed [15:0] target_wz;
    } t_in_data;

    typedef struct packed {
        logic signed [15:0] duty_front_left;
        logic signed [15:0] duty_rear_left;
        logic signed [15:0] duty_front_right;
        logic signed [15:0] duty_rear_right;
    } t_out_data;

    typedef struct packed {
        logic       load;
        logic       turn;
        logic       issue;
        logic [1:0] idx;
        logic       commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

[design/smd_if.sv]
// smd_if: valid/ready channel interfaces for request, result and register writes.
// Depends on smd_pkg for the payload types.
`default_nettype none

interface smd_in_if;
    import smd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface smd_out_if;
    import smd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface smd_cfg_if;
    import smd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/slew_limited_mecanum_drive.sv]
// slew_limited_mecanum_drive: top level of the slew-limited mecanum drive.
// Depends on smd_pkg, smd_if, smd_ctrl and smd_dp.
//
// Usage:
//   i_in carries one request per control tick: target_vx, target_vy, target_wz
//   (signed Q4.12). o_out returns one result per request: four wheel duties,
//   signed Q2.14, in front-left, rear-left, front-right, rear-right order.
//   i_cfg writes step_linear (0), step_turn (1), arm_length (2), duty_gain (3)
//   and duty_max (4); it is always ready, other indexes are dropped.
// Timing:
//   A request is accepted only while the sequencer is idle; the slew is
//   registered at the accepting edge. Then come one turn product, four wheel
//   issues through the single shared gain multiplier, a drain of the multiply
//   and round stages and one commit, after which o_out.valid rises. The next
//   request is taken only when the sequencer is back in idle after the commit.
// Reset and stall:
//   Reset loads the register defaults and zeroes the profiled velocities.
//   The result register holds while o_out.ready is low; a new request can be
//   taken and processed meanwhile, but its commit waits until the slot frees.
`default_nettype none

module slew_limited_mecanum_drive (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    smd_in_if.sink      i_in,
    smd_out_if.source   o_out,
    smd_cfg_if.sink     i_cfg
);
    import smd_pkg::*;

    t_dp_cmd w_cmd;

    assign i_cfg.ready = 1'b1;

    smd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    smd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_data  (o_out.data)
    );

endmodule

`default_nettype wire

[design/smd_ctrl.sv]
// smd_ctrl: sequencer of one request: slew, turn product, four wheel issues, drain, commit.
// Depends on smd_pkg for the datapath command struct.
`default_nettype none

module smd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output smd_pkg::t_dp_cmd     o_cmd
);
    import smd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TURN  = 5'b00010,
        S_WHEEL = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.idx   = r_cnt;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TURN;
                end
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                n_cnt      = 2'd0;
                n_state    = S_WHEEL;
            end
            S_WHEEL: begin
                o_cmd.issue = 1'b1;
                n_cnt       = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_cnt   = 2'd0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit while result register occupied");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result valid rose outside finish state");

    a_first_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && o_cmd.idx == 2'd0) |-> $past(r_state == S_TURN))
        else $error("first wheel issue not after turn product");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_TURN))
        else $error("accepted request did not start sequence");
`endif

endmodule

`default_nettype wire

[design/smd_dp.sv]
// smd_dp: register file, slew limiter, turn product, shared wheel multiplier, round and clamp.
// Depends on smd_pkg; driven by commands from smd_ctrl.
`default_nettype none

module smd_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire smd_pkg::t_dp_cmd                i_cmd,
    input  wire smd_pkg::t_in_data               i_in_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [smd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [smd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output smd_pkg::t_out_data                   o_out_data
);
    import smd_pkg::*;

    function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [14:0] step);
        logic signed [16:0] diff;
        logic signed [16:0] lim;
        diff = $signed({tgt[15], tgt}) - $signed({cur[15], cur});
        lim  = $signed({2'b00, step});
        if (diff > lim) begin
            diff = lim;
        end else if (diff < -lim) begin
            diff = -lim;
        end
        return cur + diff[15:0];
    endfunction

    logic [14:0] r_step_lin, r_step_turn, r_dmax;
    logic [15:0] r_arm, r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_lin  <= RST_STEP_LINEAR;
            r_step_turn <= RST_STEP_TURN;
            r_arm       <= RST_ARM_LENGTH;
            r_gain      <= RST_DUTY_GAIN;
            r_dmax      <= RST_DUTY_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STEP_LINEAR: r_step_lin  <= i_cfg_data[14:0];
                CFG_STEP_TURN:   r_step_turn <= i_cfg_data[14:0];
                CFG_ARM_LENGTH:  r_arm       <= i_cfg_data;
                CFG_DUTY_GAIN:   r_gain      <= i_cfg_data;
                CFG_DUTY_MAX:    r_dmax      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // profiled velocities
    logic signed [15:0] r_vx, r_vy, r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= '0;
            r_vy <= '0;
            r_wz <= '0;
        end else if (i_cmd.load) begin
            r_vx <= slew(r_vx, i_in_data.target_vx, r_step_lin);
            r_vy <= slew(r_vy, i_in_data.target_vy, r_step_lin);
            r_wz <= slew(r_wz, i_in_data.target_wz, r_step_turn);
        end
    end

    // turn product and linear terms, Q8.24 once shifted
    logic signed [32:0] w_turn;
    logic signed [32:0] r_turn;
    logic signed [16:0] r_lin_a, r_lin_b;

    assign w_turn = $signed({1'b0, r_arm}) * r_wz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.turn) begin
            r_turn  <= w_turn;
            r_lin_a <= $signed({r_vx[15], r_vx}) - $signed({r_vy[15], r_vy});
            r_lin_b <= $signed({r_vx[15], r_vx}) + $signed({r_vy[15], r_vy});
        end
    end

    // issue stage: wheel sum and magnitude
    logic signed [16:0] w_lin;
    logic signed [33:0] w_lin_ext, w_turn_ext, w_sum, w_abs;
    logic [31:0]        r_mag;
    logic               r_iss_v, r_iss_neg;
    logic [1:0]         r_iss_idx;

    assign w_lin      = i_cmd.idx[0] ? r_lin_b : r_lin_a;
    assign w_lin_ext  = $signed({{5{w_lin[16]}}, w_lin, 12'b0});
    assign w_turn_ext = $signed({r_turn[32], r_turn});
    assign w_sum      = i_cmd.idx[1] ? (w_turn_ext + w_lin_ext) : (w_turn_ext - w_lin_ext);
    assign w_abs      = w_sum[33] ? -w_sum : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_v <= 1'b0;
        end else begin
            r_iss_v <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_mag     <= w_abs[31:0];
            r_iss_neg <= w_sum[33];
            r_iss_idx <= i_cmd.idx;
        end
    end

    // multiply stage
    logic [47:0] r_prod;
    logic        r_mul_v, r_mul_neg;
    logic [1:0]  r_mul_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else begin
            r_mul_v <= r_iss_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_iss_v) begin
            r_prod    <= r_mag * r_gain;
            r_mul_neg <= r_iss_neg;
            r_mul_idx <= r_iss_idx;
        end
    end

    // round half away from zero, clamp, apply sign
    logic [48:0]        w_rnd;
    logic [24:0]        w_q;
    logic [14:0]        w_clip;
    logic signed [15:0] w_duty;
    logic signed [15:0] r_duty [NUM_WHEELS];

    assign w_rnd  = {1'b0, r_prod} + (49'd1 << (ROUND_SHIFT - 1));
    assign w_q    = w_rnd[48:ROUND_SHIFT];
    assign w_clip = (w_q > {10'b0, r_dmax}) ? r_dmax : w_q[14:0];
    assign w_duty = r_mul_neg ? -$signed({1'b0, w_clip}) : $signed({1'b0, w_clip});

    always_ff @(posedge i_clk) begin
        if (r_mul_v) begin
            r_duty[r_mul_idx] <= w_duty;
        end
    end

    t_out_data r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.duty_front_left  <= r_duty[0];
            r_out.duty_rear_left   <= r_duty[1];
            r_out.duty_front_right <= r_duty[2];
            r_out.duty_rear_right  <= r_duty[3];
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[tb/mecanum_duty_checker.sv]
`timescale 1ns / 1ps
// mecanum_duty_checker: watches the tick, duty and register channels of the drive,
// predicts the four wheel duties per accepted request and compares them in order.
// Depends on smd_pkg and the channel interfaces in smd_if.

module mecanum_duty_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    smd_in_if    i_tick,
    smd_out_if   i_duty,
    smd_cfg_if   i_reg,
    output int   o_mismatches,
    output int   o_pending
);
    import smd_pkg::*;

    logic        [14:0] step_lin_q;
    logic        [14:0] step_turn_q;
    logic        [15:0] arm_q;
    logic        [15:0] gain_q;
    logic        [14:0] duty_max_q;
    logic signed [15:0] prof_vx;
    logic signed [15:0] prof_vy;
    logic signed [15:0] prof_wz;

    t_out_data expected_duties[$];
    int        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report(string msg);
        if (mismatch_count < 100) $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic signed [15:0] slew_toward(logic signed [15:0] cur,
                                                      logic signed [15:0] tgt,
                                                      logic [14:0] step);
        int diff;
        int lim;
        diff = int'(tgt) - int'(cur);
        lim  = int'(step);
        if (diff > lim) begin
            diff = lim;
        end else if (diff < -lim) begin
            diff = -lim;
        end
        return 16'(int'(cur) + diff);
    endfunction

    // Q8.24 wheel sum -> Q2.14 duty, rounded half away from zero, clamped.
    function automatic logic signed [15:0] wheel_duty(longint sum);
        logic              neg;
        longint unsigned   mag;
        longint unsigned   prod;
        longint unsigned   q14;
        neg  = sum < 0;
        mag  = neg ? -sum : sum;
        prod = mag * longint'(gain_q);
        q14  = (prod + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (q14 > longint'(duty_max_q)) q14 = longint'(duty_max_q);
        return neg ? -16'(q14) : 16'(q14);
    endfunction

    function automatic t_out_data predict_duties(t_in_data req);
        longint    lin_a;
        longint    lin_b;
        longint    turn;
        t_out_data res;
        prof_vx = slew_toward(prof_vx, req.target_vx, step_lin_q);
        prof_vy = slew_toward(prof_vy, req.target_vy, step_lin_q);
        prof_wz = slew_toward(prof_wz, req.target_wz, step_turn_q);
        lin_a = (longint'(prof_vx) - longint'(prof_vy)) * 4096;
        lin_b = (longint'(prof_vx) + longint'(prof_vy)) * 4096;
        turn  = longint'(arm_q) * longint'(prof_wz);
        res.duty_front_left  = wheel_duty(-(lin_a - turn));
        res.duty_rear_left   = wheel_duty(-(lin_b - turn));
        res.duty_front_right = wheel_duty(lin_a + turn);
        res.duty_rear_right  = wheel_duty(lin_b + turn);
        return res;
    endfunction

    task automatic store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_STEP_LINEAR: step_lin_q  = value[14:0];
            CFG_STEP_TURN:   step_turn_q = value[14:0];
            CFG_ARM_LENGTH:  arm_q       = value;
            CFG_DUTY_GAIN:   gain_q      = value;
            CFG_DUTY_MAX:    duty_max_q  = value[14:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(string name, logic signed [15:0] got,
                                 logic signed [15:0] want);
        if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_out_data want;
        t_out_data got;
        if (!i_rst_n) begin
            step_lin_q  = RST_STEP_LINEAR;
            step_turn_q = RST_STEP_TURN;
            arm_q       = RST_ARM_LENGTH;
            gain_q      = RST_DUTY_GAIN;
            duty_max_q  = RST_DUTY_MAX;
            prof_vx     = '0;
            prof_vy     = '0;
            prof_wz     = '0;
            expected_duties.delete();
        end else begin
            if (i_duty.valid && i_duty.ready) begin
                got = i_duty.data;
                if (expected_duties.size() == 0) begin
                    report("duty result with no request outstanding");
                end else begin
                    want = expected_duties.pop_front();
                    compare_field("duty_front_left", got.duty_front_left,
                                  want.duty_front_left);
                    compare_field("duty_rear_left", got.duty_rear_left,
                                  want.duty_rear_left);
                    compare_field("duty_front_right", got.duty_front_right,
                                  want.duty_front_right);
                    compare_field("duty_rear_right", got.duty_rear_right,
                                  want.duty_rear_right);
                end
            end
            if (i_reg.valid && i_reg.ready) store_reg(i_reg.index, i_reg.data);
            if (i_tick.valid && i_tick.ready)
                expected_duties = {expected_duties, predict_duties(i_tick.data)};
        end
        o_pending <= expected_duties.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus and verdict for slew_limited_mecanum_drive; directed ticks, then
// random ticks under random register settings. Depends on smd_pkg, smd_if, the DUT
// and mecanum_duty_checker, which does all prediction and comparison.

module tb;
    import smd_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RAND_PHASES     = 8;
    localparam int TICKS_PER_PHASE = 175;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   cycle_count = 0;

    smd_in_if  tick_ch();
    smd_out_if duty_ch();
    smd_cfg_if reg_ch();

    slew_limited_mecanum_drive dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (duty_ch),
        .i_cfg   (reg_ch)
    );

    mecanum_duty_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_duty       (duty_ch),
        .i_reg        (reg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result-side backpressure
    initial begin
        int r;
        duty_ch.ready <= 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                duty_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else if (r < 92) begin
                duty_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                duty_ch.ready <= 1'b0;
                repeat ($urandom_range(15, 60)) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_tick(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [15:0] wz);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= '{target_vx: vx, target_vy: vy, target_wz: wz};
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    task automatic drain_ticks();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= value;
        do @(posedge i_clk); while (!reg_ch.ready);
    endtask

    task automatic apply_config(logic [CFG_DATA_W-1:0] lin, logic [CFG_DATA_W-1:0] turn,
                                logic [CFG_DATA_W-1:0] arm, logic [CFG_DATA_W-1:0] gain,
                                logic [CFG_DATA_W-1:0] dmax);
        write_reg(CFG_STEP_LINEAR, lin);
        write_reg(CFG_STEP_TURN, turn);
        write_reg(CFG_ARM_LENGTH, arm);
        write_reg(CFG_DUTY_GAIN, gain);
        write_reg(CFG_DUTY_MAX, dmax);
        // unmapped index, must be dropped
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_DUTY_MAX) + 1, 7)),
                      CFG_DATA_W'($urandom));
        reg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg(int maxv, int rstv, int typ);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 25) return CFG_DATA_W'(maxv);
        if (r < 37) return CFG_DATA_W'(rstv);
        if (r < 47) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(0, typ));
    endfunction

    function automatic logic signed [15:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 16'($urandom);
        if (r < 55) begin
            case ($urandom_range(0, 4))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sd0;
                3: return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        return 16'(int'($urandom_range(0, 16383)) - 8192);
    endfunction

    initial begin
        int                 sent;
        int                 run;
        logic signed [15:0] tvx;
        logic signed [15:0] tvy;
        logic signed [15:0] twz;

        i_rst_n       <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        reg_ch.valid  <= 1'b0;
        reg_ch.index  <= '0;
        reg_ch.data   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, slow profile
        send_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000, 16'sh8000);
        send_tick(16'sd0, 16'sd0, 16'sd0);
        drain_ticks();

        // full steps, max arm and gain; duty limit written wide and masked
        apply_config(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000, 16'sh8000);
        send_tick(16'sh8000, 16'sh8000, 16'sh8000);
        send_tick(16'sh5555, -16'sh2AAB, 16'sh1234);
        drain_ticks();

        // zero steps: profile holds
        apply_config(16'd0, 16'd0, 16'd1331, 16'd15481, 16'd16384);
        send_tick(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_tick(16'sd0, 16'sd0, 16'sd0);
        drain_ticks();

        // unity gain, no arm: duty = 4*v, limit hit exactly and then exceeded
        apply_config(16'h7FFF, 16'h7FFF, 16'd0, 16'd16384, 16'd4000);
        send_tick(16'sd1000, 16'sd0, 16'sd0);
        send_tick(16'sd1000, 16'sd0, 16'sd0);
        send_tick(-16'sd1001, 16'sd0, 16'sd0);
        send_tick(16'sd0, 16'sd1000, 16'sd0);
        drain_ticks();

        // zero duty limit
        apply_config(16'd300, 16'd900, 16'd2000, 16'd30000, 16'd0);
        send_tick(16'sd5000, -16'sd5000, 16'sd5000);
        send_tick(-16'sd5000, 16'sd5000, -16'sd5000);
        drain_ticks();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            apply_config(pick_reg(32767, int'(RST_STEP_LINEAR), 2000),
                         pick_reg(32767, int'(RST_STEP_TURN), 4000),
                         pick_reg(65535, int'(RST_ARM_LENGTH), 8000),
                         pick_reg(65535, int'(RST_DUTY_GAIN), 65535),
                         pick_reg(16384, int'(RST_DUTY_MAX), 16384));
            sent = 0;
            while (sent < TICKS_PER_PHASE) begin
                tvx = pick_target();
                tvy = pick_target();
                twz = pick_target();
                run = $urandom_range(1, 24);
                for (int k = 0; k < run && sent < TICKS_PER_PHASE; k++) begin
                    if ($urandom_range(0, 9) == 0) tvx = pick_target();
                    if ($urandom_range(0, 9) == 0) tvy = pick_target();
                    if ($urandom_range(0, 9) == 0) twz = pick_target();
                    send_tick(tvx, tvy, twz);
                    sent++;
                end
            end
            drain_ticks();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
